// ===== design/temporal_chroma_denoise_macros.svh =====
// Assertion macros for the temporal chroma denoise block.
// Depends on nothing; the including module must have clock and reset signals.
`ifndef TEMPORAL_CHROMA_DENOISE_MACROS_SVH
`define TEMPORAL_CHROMA_DENOISE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCD_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("temporal_chroma_denoise: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("temporal_chroma_denoise: next-cycle check failed");

`endif

// ===== design/tcd_pkg.sv =====
// Shared types, codes and constants of the temporal chroma denoise block.
// No dependencies; every design module imports this package.
package tcd_pkg;

   localparam int TABLE_ENTRIES_DEF = 256;
   localparam int SUM_W             = 36;
   localparam int THRESH_W          = 34;
   localparam int CSR_DATA_W        = 34;

   localparam logic [SUM_W-1:0] SUM_MAX    = '1;
   localparam logic [1:0]       SHIFT_MAX  = 2'd2;
   localparam logic [25:0]      ROUND_HALF = 26'd32768;

   // Item function codes.
   localparam logic [1:0] FUNC_PIXEL = 2'd0;
   localparam logic [1:0] FUNC_LOAD  = 2'd1;
   localparam logic [1:0] FUNC_FRAME = 2'd2;

   // Weight table selects for load items.
   localparam logic [1:0] TSEL_LUMA = 2'd0;
   localparam logic [1:0] TSEL_U    = 2'd1;
   localparam logic [1:0] TSEL_V    = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_SCENE_CHROMA = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD    = 2'd1;
   localparam logic [1:0] CSR_LUMA_SHIFT   = 2'd2;

   // Control from the first stage to the scene-difference accumulator.
   typedef struct packed {
      logic step;
      logic clear;
      logic end_of_row;
   } tcd_scene_ctl_type;

   function automatic logic [7:0] absdiff8(input logic [7:0] a, input logic [7:0] b);
      absdiff8 = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

// ===== design/temporal_chroma_denoise.sv =====
// Temporal chroma denoise: weight table memories, first stage and configuration registers.
// Depends on tcd_pkg, tcd_weight_mem, tcd_scene_acc, tcd_blend_pipe and the macro header.
//
// Use: items enter on the req_ channel (valid/ready). A pixel item gives one result on
// the rsp_ channel: blended U and V and the sticky scene-change flag after that pixel's
// row-end check. Load items write one weight table entry and new-frame items clear the
// scene sum and flag; neither gives a result. Items leave in the order they entered.
// A pixel is registered at table read, weight product and blend before rsp_valid rises.
// One item can be accepted every cycle while req_ready is high; the three table memories
// are read at acceptance and written by load items, so a pixel sees every load accepted
// before it. The scene sum is updated in the stage after the read. Configuration is
// written over the always-ready csr_ channel; the user must do so only while idle, as the
// block does not enforce it. Reset clears the pipeline, the scene state, the registers and
// the table valid bits, so every table reads as zero until loaded; no clearing pass is
// needed. When the receiver holds rsp_ready low the result register holds its item and the
// earlier stages keep filling; req_ready drops once every stage holds an item.
`include "temporal_chroma_denoise_macros.svh"
module temporal_chroma_denoise import tcd_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_func,
   input  logic [7:0]            req_cur_luma,
   input  logic [7:0]            req_prev_luma,
   input  logic [7:0]            req_cur_u,
   input  logic [7:0]            req_cur_v,
   input  logic [7:0]            req_prev_u,
   input  logic [7:0]            req_prev_v,
   input  logic                  req_end_of_row,
   input  logic [1:0]            req_table_select,
   input  logic [7:0]            req_table_index,
   input  logic [7:0]            req_table_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_out_u,
   output logic [7:0]            rsp_out_v,
   output logic                  rsp_scene_change,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [1:0]            csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW = $clog2(TABLE_ENTRIES);

   logic                cfg_chroma_ff;
   logic [THRESH_W-1:0] cfg_thresh_ff;
   logic [1:0]          cfg_shift_ff;

   logic       s1_valid_ff, s1_valid_in;
   logic       s1_frame_ff, s1_frame_in;
   logic [7:0] s1_dy_ff, s1_du_ff, s1_dv_ff;
   logic [7:0] s1_cur_u_ff, s1_cur_v_ff, s1_prev_u_ff, s1_prev_v_ff;
   logic       s1_eor_ff;

   logic       en1, accept, is_load;
   logic       wr_luma, wr_u, wr_v;
   logic [7:0] dy_in, du_in, dv_in;
   logic [7:0] wgt_y, wgt_u, wgt_v;
   logic       blend_ready;
   logic       scene_next, scene_flag;

   tcd_scene_ctl_type scene_ctl;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_chroma_ff <= 1'b0;
         cfg_thresh_ff <= '0;
         cfg_shift_ff  <= 2'd0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCENE_CHROMA: cfg_chroma_ff <= csr_data[0];
            CSR_THRESHOLD:    cfg_thresh_ff <= csr_data[THRESH_W-1:0];
            CSR_LUMA_SHIFT:   cfg_shift_ff  <= csr_data[1:0];
            default: begin
            end
         endcase
      end
   end

   // First stage: table reads at acceptance, differences registered alongside.
   assign en1       = !s1_valid_ff || blend_ready;
   assign req_ready = en1;
   assign accept    = req_valid && en1;
   assign is_load   = req_func == FUNC_LOAD;
   assign wr_luma   = accept && is_load && (req_table_select == TSEL_LUMA);
   assign wr_u      = accept && is_load && (req_table_select == TSEL_U);
   assign wr_v      = accept && is_load && (req_table_select == TSEL_V);

   assign dy_in = absdiff8(req_cur_luma, req_prev_luma);
   assign du_in = absdiff8(req_cur_u, req_prev_u);
   assign dv_in = absdiff8(req_cur_v, req_prev_v);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_frame_in = s1_frame_ff;
      if (en1) begin
         // Only pixels and new-frame items travel on; loads finish at the memory write.
         s1_valid_in = req_valid && ((req_func == FUNC_PIXEL) || (req_func == FUNC_FRAME));
         s1_frame_in = req_func == FUNC_FRAME;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s1_frame_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s1_frame_ff <= s1_frame_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_dy_ff     <= dy_in;
         s1_du_ff     <= du_in;
         s1_dv_ff     <= dv_in;
         s1_cur_u_ff  <= req_cur_u;
         s1_cur_v_ff  <= req_cur_v;
         s1_prev_u_ff <= req_prev_u;
         s1_prev_v_ff <= req_prev_v;
         s1_eor_ff    <= req_end_of_row;
      end
   end

   tcd_weight_mem #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_luma_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_luma),
      .wr_addr (req_table_index[AW-1:0]),
      .wr_data (req_table_value),
      .rd_en   (en1),
      .rd_addr (dy_in[AW-1:0]),
      .rd_data (wgt_y)
   );

   tcd_weight_mem #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_u),
      .wr_addr (req_table_index[AW-1:0]),
      .wr_data (req_table_value),
      .rd_en   (en1),
      .rd_addr (du_in[AW-1:0]),
      .rd_data (wgt_u)
   );

   tcd_weight_mem #(.ENTRIES(TABLE_ENTRIES), .AW(AW)) u_v_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (wr_v),
      .wr_addr (req_table_index[AW-1:0]),
      .wr_data (req_table_value),
      .rd_en   (en1),
      .rd_addr (dv_in[AW-1:0]),
      .rd_data (wgt_v)
   );

   always_comb begin
      scene_ctl.step       = s1_valid_ff && blend_ready;
      scene_ctl.clear      = s1_frame_ff;
      scene_ctl.end_of_row = s1_eor_ff;
   end

   tcd_scene_acc u_scene (
      .clock          (clock),
      .reset          (reset),
      .ctl            (scene_ctl),
      .cfg_use_chroma (cfg_chroma_ff),
      .cfg_threshold  (cfg_thresh_ff),
      .cfg_shift      (cfg_shift_ff),
      .diff_y         (s1_dy_ff),
      .diff_u         (s1_du_ff),
      .diff_v         (s1_dv_ff),
      .flag_next      (scene_next),
      .flag           (scene_flag)
   );

   tcd_blend_pipe u_blend (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (s1_valid_ff && !s1_frame_ff),
      .in_ready         (blend_ready),
      .in_wgt_y         (wgt_y),
      .in_wgt_u         (wgt_u),
      .in_wgt_v         (wgt_v),
      .in_cur_u         (s1_cur_u_ff),
      .in_cur_v         (s1_cur_v_ff),
      .in_prev_u        (s1_prev_u_ff),
      .in_prev_v        (s1_prev_v_ff),
      .in_scene         (scene_next),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_u        (rsp_out_u),
      .rsp_out_v        (rsp_out_v),
      .rsp_scene_change (rsp_scene_change)
   );

   // A new-frame item leaving the first stage clears the flag.
   `TCD_ASSERT_NEXT(a_frame_clears_flag, s1_valid_ff && s1_frame_ff && blend_ready, !scene_flag)
   // Once set, the flag survives every pixel until a new-frame item.
   `TCD_ASSERT_NEXT(a_flag_sticky, scene_ctl.step && !s1_frame_ff && scene_flag, scene_flag)
   // A table load never leaves an item behind in the first stage.
   `TCD_ASSERT_NEXT(a_load_no_item, wr_luma || wr_u || wr_v, !s1_valid_ff)

endmodule

// ===== design/tcd_weight_mem.sv =====
// One weight table: a synchronous memory with registered read and per-entry valid bits.
// Depends on tcd_pkg. Entries never written read as zero.
module tcd_weight_mem import tcd_pkg::*; #(
   parameter int ENTRIES = TABLE_ENTRIES_DEF,
   parameter int AW      = $clog2(ENTRIES)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0]         mem_ff [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;
   logic [7:0]         rd_data_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : 8'd0;

endmodule

// ===== design/tcd_scene_acc.sv =====
// Saturating scene-difference sum and the sticky scene-change flag.
// Depends on tcd_pkg for widths, constants and the control struct.
module tcd_scene_acc import tcd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  tcd_scene_ctl_type   ctl,
   input  logic                cfg_use_chroma,
   input  logic [THRESH_W-1:0] cfg_threshold,
   input  logic [1:0]          cfg_shift,
   input  logic [7:0]          diff_y,
   input  logic [7:0]          diff_u,
   input  logic [7:0]          diff_v,
   output logic                flag_next,
   output logic                flag
);

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic             flag_ff, flag_in;
   logic [1:0]       shift_eff;
   logic [9:0]       luma_term;
   logic [8:0]       chroma_term;
   logic [10:0]      incr;
   logic [SUM_W:0]   total;
   logic [SUM_W-1:0] sum_sat;
   logic             over;

   always_comb begin
      shift_eff   = (cfg_shift > SHIFT_MAX) ? SHIFT_MAX : cfg_shift;
      luma_term   = 10'(diff_y) << shift_eff;
      chroma_term = cfg_use_chroma ? (9'(diff_u) + 9'(diff_v)) : 9'd0;
      incr        = 11'(luma_term) + 11'(chroma_term);
      total       = {1'b0, sum_ff} + (SUM_W+1)'(incr);
      // Both increments are non-negative, so one clamp covers the two additions.
      sum_sat     = total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
      over        = sum_sat > SUM_W'(cfg_threshold);
      flag_next   = flag_ff | (ctl.end_of_row & over);

      sum_in  = sum_ff;
      flag_in = flag_ff;
      if (ctl.step) begin
         if (ctl.clear) begin
            sum_in  = '0;
            flag_in = 1'b0;
         end else begin
            sum_in  = sum_sat;
            flag_in = flag_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         flag_ff <= 1'b0;
      end else begin
         sum_ff  <= sum_in;
         flag_ff <= flag_in;
      end
   end

   assign flag = flag_ff;

endmodule

// ===== design/tcd_blend_pipe.sv =====
// Weight product stage and blend stage with the result register.
// Depends on tcd_pkg for the rounding constant.
module tcd_blend_pipe import tcd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_wgt_y,
   input  logic [7:0] in_wgt_u,
   input  logic [7:0] in_wgt_v,
   input  logic [7:0] in_cur_u,
   input  logic [7:0] in_cur_v,
   input  logic [7:0] in_prev_u,
   input  logic [7:0] in_prev_v,
   input  logic       in_scene,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_u,
   output logic [7:0] rsp_out_v,
   output logic       rsp_scene_change
);

   logic               s2_valid_ff, s2_valid_in;
   logic [15:0]        w_u_ff, w_v_ff;
   logic signed [8:0]  d_u_ff, d_v_ff;
   logic [7:0]         cur_u_ff, cur_v_ff;
   logic               scene_s2_ff;
   logic               out_valid_ff, out_valid_in;
   logic [7:0]         out_u_ff, out_v_ff;
   logic               out_scene_ff;
   logic               en2, en3;
   logic signed [25:0] prod_u, prod_v;
   logic [25:0]        round_u, round_v;

   assign en3      = !out_valid_ff || rsp_ready;
   assign en2      = !s2_valid_ff || en3;
   assign in_ready = en2;

   always_comb begin
      s2_valid_in  = en2 ? in_valid : s2_valid_ff;
      out_valid_in = en3 ? s2_valid_ff : out_valid_ff;
   end

   // out = (w*prev + (65536-w)*cur + 32768) >> 16 = cur + floor((w*(prev-cur) + 32768) / 65536).
   assign prod_u  = $signed({1'b0, w_u_ff}) * d_u_ff;
   assign prod_v  = $signed({1'b0, w_v_ff}) * d_v_ff;
   assign round_u = prod_u + ROUND_HALF;
   assign round_v = prod_v + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (en2) begin
         w_u_ff      <= 16'(in_wgt_y) * 16'(in_wgt_u);
         w_v_ff      <= 16'(in_wgt_y) * 16'(in_wgt_v);
         d_u_ff      <= $signed({1'b0, in_prev_u}) - $signed({1'b0, in_cur_u});
         d_v_ff      <= $signed({1'b0, in_prev_v}) - $signed({1'b0, in_cur_v});
         cur_u_ff    <= in_cur_u;
         cur_v_ff    <= in_cur_v;
         scene_s2_ff <= in_scene;
      end
      if (en3) begin
         out_u_ff     <= cur_u_ff + round_u[23:16];
         out_v_ff     <= cur_v_ff + round_v[23:16];
         out_scene_ff <= scene_s2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_u        = out_u_ff;
   assign rsp_out_v        = out_v_ff;
   assign rsp_scene_change = out_scene_ff;

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for temporal_chroma_denoise: directed rows, then randomized
// frames of pixel, table-load and new-frame items over several register settings.
// Depends on tcd_pkg and the temporal_chroma_denoise RTL.
module testbench;
   import tcd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_DEPTH = 256;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 70;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;
   localparam logic [1:0] TSEL_UNUSED = 2'd3;
   localparam logic [THRESH_W-1:0] THRESH_FULL = '1;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] cur_luma;
      logic [7:0] prev_luma;
      logic [7:0] cur_u;
      logic [7:0] cur_v;
      logic [7:0] prev_u;
      logic [7:0] prev_v;
      logic       end_of_row;
      logic [1:0] table_select;
      logic [7:0] table_index;
      logic [7:0] table_value;
   } chroma_item_t;

   typedef struct packed {
      logic [7:0] out_u;
      logic [7:0] out_v;
      logic       scene_change;
   } denoise_result_t;

   typedef struct {
      chroma_item_t    item;
      bit              typed;
      denoise_result_t want;
   } directed_row_t;

   typedef struct {
      logic                uses_chroma;
      logic [THRESH_W-1:0] threshold;
      logic [1:0]          luma_shift;
      bit                  dense;
   } reg_setting_t;

   localparam denoise_result_t NO_RESULT = '0;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [1:0]            req_func;
   logic [7:0]            req_cur_luma;
   logic [7:0]            req_prev_luma;
   logic [7:0]            req_cur_u;
   logic [7:0]            req_cur_v;
   logic [7:0]            req_prev_u;
   logic [7:0]            req_prev_v;
   logic                  req_end_of_row;
   logic [1:0]            req_table_select;
   logic [7:0]            req_table_index;
   logic [7:0]            req_table_value;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [7:0]            rsp_out_u;
   logic [7:0]            rsp_out_v;
   logic                  rsp_scene_change;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [1:0]            csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // Predicted block state and register copies.
   logic [7:0]          luma_weights [TABLE_DEPTH] = '{default: 8'd0};
   logic [7:0]          u_weights [TABLE_DEPTH] = '{default: 8'd0};
   logic [7:0]          v_weights [TABLE_DEPTH] = '{default: 8'd0};
   logic [SUM_W-1:0]    scene_sum = '0;
   logic                scene_flag = 1'b0;
   logic                cfg_uses_chroma = 1'b0;
   logic [THRESH_W-1:0] cfg_threshold = '0;
   logic [1:0]          cfg_luma_shift = 2'd0;

   denoise_result_t pending_results[$];
   int              fail_count = 0;
   int unsigned     cycle_count = 0;
   bit              hold_off_req = 1'b0;

   temporal_chroma_denoise dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [7:0] magnitude_gap(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic logic [SUM_W-1:0] saturating_add(input logic [SUM_W-1:0] acc,
                                                       input logic [SUM_W-1:0] inc);
      logic [SUM_W:0] total;
      total = {1'b0, acc} + {1'b0, inc};
      return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
   endfunction

   function automatic logic [7:0] mix_chroma(input logic [15:0] w, input logic [7:0] prev,
                                             input logic [7:0] cur);
      logic [31:0] acc;
      acc = w * prev + (32'd65536 - w) * cur + 32'd32768;
      return acc[23:16];
   endfunction

   // Applies one item to the predicted state; returns 1 when the item gives a result.
   function automatic bit predict_item(input chroma_item_t it, output denoise_result_t res);
      logic [7:0]  dy, du, dv;
      logic [1:0]  sh;
      logic [15:0] wu, wv;
      res = '0;
      if (it.func == FUNC_LOAD) begin
         case (it.table_select)
            TSEL_LUMA: luma_weights[it.table_index] = it.table_value;
            TSEL_U:    u_weights[it.table_index] = it.table_value;
            TSEL_V:    v_weights[it.table_index] = it.table_value;
            default: ;
         endcase
         return 1'b0;
      end
      if (it.func == FUNC_FRAME) begin
         scene_sum = '0;
         scene_flag = 1'b0;
         return 1'b0;
      end
      if (it.func != FUNC_PIXEL)
         return 1'b0;
      dy = magnitude_gap(it.cur_luma, it.prev_luma);
      du = magnitude_gap(it.cur_u, it.prev_u);
      dv = magnitude_gap(it.cur_v, it.prev_v);
      sh = (cfg_luma_shift > SHIFT_MAX) ? SHIFT_MAX : cfg_luma_shift;
      wu = luma_weights[dy] * u_weights[du];
      wv = luma_weights[dy] * v_weights[dv];
      scene_sum = saturating_add(scene_sum, SUM_W'(dy) << sh);
      if (cfg_uses_chroma)
         scene_sum = saturating_add(scene_sum, SUM_W'(du) + SUM_W'(dv));
      if (it.end_of_row && scene_sum > SUM_W'(cfg_threshold))
         scene_flag = 1'b1;
      res.out_u = mix_chroma(wu, it.prev_u, it.cur_u);
      res.out_v = mix_chroma(wv, it.prev_v, it.cur_v);
      res.scene_change = scene_flag;
      return 1'b1;
   endfunction

   function automatic chroma_item_t pixel_item(input logic [7:0] cl, input logic [7:0] pl,
                                               input logic [7:0] cu, input logic [7:0] cv,
                                               input logic [7:0] pu, input logic [7:0] pv,
                                               input logic eor);
      chroma_item_t it;
      it = '0;
      it.func = FUNC_PIXEL;
      it.cur_luma = cl;
      it.prev_luma = pl;
      it.cur_u = cu;
      it.cur_v = cv;
      it.prev_u = pu;
      it.prev_v = pv;
      it.end_of_row = eor;
      return it;
   endfunction

   function automatic chroma_item_t load_item(input logic [1:0] sel, input logic [7:0] idx,
                                              input logic [7:0] val);
      chroma_item_t it;
      it = '0;
      it.func = FUNC_LOAD;
      it.table_select = sel;
      it.table_index = idx;
      it.table_value = val;
      return it;
   endfunction

   function automatic chroma_item_t ctrl_item(input logic [1:0] func);
      chroma_item_t it;
      it = '0;
      it.func = func;
      return it;
   endfunction

   // Previous samples are mostly close to the current ones so that small table entries hit.
   function automatic logic [7:0] nearby(input logic [7:0] c);
      if ($urandom_range(2) == 0)
         return 8'($urandom);
      return 8'(c + $urandom_range(0, 16) - 8);
   endfunction

   // Offers one item and holds it until accepted; called at a rising edge.
   task automatic offer(input chroma_item_t it, input bit typed, input denoise_result_t want);
      denoise_result_t res;
      req_valid <= 1'b1;
      req_func <= it.func;
      req_cur_luma <= it.cur_luma;
      req_prev_luma <= it.prev_luma;
      req_cur_u <= it.cur_u;
      req_cur_v <= it.cur_v;
      req_prev_u <= it.prev_u;
      req_prev_v <= it.prev_v;
      req_end_of_row <= it.end_of_row;
      req_table_select <= it.table_select;
      req_table_index <= it.table_index;
      req_table_value <= it.table_value;
      do @(posedge clock); while (!req_ready);
      if (predict_item(it, res))
         pending_results.push_back(typed ? want : res);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_SCENE_CHROMA: cfg_uses_chroma = data[0];
         CSR_THRESHOLD:    cfg_threshold = data[THRESH_W-1:0];
         CSR_LUMA_SHIFT:   cfg_luma_shift = data[1:0];
         default: ;
      endcase
   endtask

   // The trailing cycles let a load or new-frame item still in flight settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly whole rows of pixels with random content, mixed with table loads, new frames
   // and a little noise. Ignored items do not count toward the total.
   task automatic stream_random(input int count, input bit dense);
      chroma_item_t it;
      int           counted, row_left, burst_left, gap, pick;
      counted = 0;
      row_left = $urandom_range(1, 12);
      burst_left = 0;
      while (counted < count) begin
         it = chroma_item_t'({$urandom, $urandom, $urandom});
         pick = $urandom_range(99);
         if (pick < 12) begin
            it.func = FUNC_LOAD;
            it.table_select = ($urandom_range(19) == 0) ? TSEL_UNUSED : 2'($urandom_range(2));
            if ($urandom_range(1) == 0)
               it.table_index = 8'($urandom_range(0, 20));
         end else if (pick < 15) begin
            it.func = FUNC_FRAME;
         end else if (pick < 17) begin
            it.func = FUNC_UNUSED;
         end else begin
            it.func = FUNC_PIXEL;
            it.prev_luma = nearby(it.cur_luma);
            it.prev_u = nearby(it.cur_u);
            it.prev_v = nearby(it.cur_v);
            row_left--;
            it.end_of_row = (row_left == 0);
            if (row_left == 0)
               row_left = $urandom_range(1, 12);
            if ($urandom_range(24) == 0)
               it.end_of_row = ~it.end_of_row;
         end
         offer(it, 1'b0, NO_RESULT);
         if (!(it.func == FUNC_UNUSED ||
               (it.func == FUNC_LOAD && it.table_select == TSEL_UNUSED)))
            counted++;
         if (!dense) begin
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = $urandom_range(0, 7);
               if (gap != 0) begin
                  req_valid <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
         end
      end
   endtask

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      denoise_result_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("result with none expected: out_u %0d out_v %0d scene_change %0d",
                   rsp_out_u, rsp_out_v, rsp_scene_change);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("out_u", want.out_u, rsp_out_u);
            check_field("out_v", want.out_v, rsp_out_v);
            check_field("scene_change", 8'(want.scene_change), 8'(rsp_scene_change));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: stretches of differing stall density, plus one long hold-off on request.
   initial begin : result_stalls
      int mode_left, stall_pct, hold_left;
      mode_left = 0;
      stall_pct = 0;
      hold_left = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(10, 60);
               case ($urandom_range(3))
                  0: stall_pct = 0;
                  1: stall_pct = 20;
                  2: stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end
            mode_left--;
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   initial begin : stimulus
      directed_row_t directed_rows[$];
      reg_setting_t  settings[$];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_PIXEL;
      req_cur_luma <= '0;
      req_prev_luma <= '0;
      req_cur_u <= '0;
      req_cur_v <= '0;
      req_prev_u <= '0;
      req_prev_v <= '0;
      req_end_of_row <= 1'b0;
      req_table_select <= TSEL_LUMA;
      req_table_index <= '0;
      req_table_value <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_SCENE_CHROMA;
      csr_data <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // With all tables at zero the output equals the current chroma, and with a zero
      // threshold any nonzero sum at a row end sets the flag.
      directed_rows.push_back('{pixel_item(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1),
                                1'b1, '{8'd0, 8'd0, 1'b0}});
      directed_rows.push_back('{pixel_item(8'd7, 8'd7, 8'd255, 8'd255, 8'd0, 8'd0, 1'b0),
                                1'b1, '{8'd255, 8'd255, 1'b0}});
      directed_rows.push_back('{pixel_item(8'd255, 8'd0, 8'hAA, 8'h55, 8'h55, 8'hAA, 1'b1),
                                1'b1, '{8'hAA, 8'h55, 1'b1}});
      // The flag stays set for the rest of the frame.
      directed_rows.push_back('{pixel_item(8'd3, 8'd3, 8'd1, 8'd2, 8'd1, 8'd2, 1'b0),
                                1'b1, '{8'd1, 8'd2, 1'b1}});
      directed_rows.push_back('{ctrl_item(FUNC_FRAME), 1'b0, NO_RESULT});
      directed_rows.push_back('{pixel_item(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1),
                                1'b1, '{8'd0, 8'd0, 1'b0}});
      directed_rows.push_back('{ctrl_item(FUNC_UNUSED), 1'b0, NO_RESULT});
      directed_rows.push_back('{load_item(TSEL_LUMA, 8'd255, 8'd255), 1'b0, NO_RESULT});
      directed_rows.push_back('{load_item(TSEL_U, 8'd255, 8'd255), 1'b0, NO_RESULT});
      directed_rows.push_back('{load_item(TSEL_V, 8'd255, 8'd255), 1'b0, NO_RESULT});
      directed_rows.push_back('{load_item(TSEL_LUMA, 8'd0, 8'h80), 1'b0, NO_RESULT});
      directed_rows.push_back('{load_item(TSEL_U, 8'd0, 8'hFF), 1'b0, NO_RESULT});
      directed_rows.push_back('{load_item(TSEL_V, 8'd0, 8'h01), 1'b0, NO_RESULT});
      // A load with an unused select must leave every table alone.
      directed_rows.push_back('{load_item(TSEL_UNUSED, 8'd0, 8'h00), 1'b0, NO_RESULT});
      directed_rows.push_back('{pixel_item(8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 1'b0),
                                1'b0, NO_RESULT});
      directed_rows.push_back('{pixel_item(8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 1'b1),
                                1'b0, NO_RESULT});
      directed_rows.push_back('{pixel_item(8'h5A, 8'h5A, 8'h5A, 8'hA5, 8'h5A, 8'hA5, 1'b0),
                                1'b0, NO_RESULT});
      directed_rows.push_back('{pixel_item(8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1),
                                1'b0, NO_RESULT});
      directed_rows.push_back('{ctrl_item(FUNC_FRAME), 1'b0, NO_RESULT});
      directed_rows.push_back('{pixel_item(8'd255, 8'd255, 8'd128, 8'd127, 8'd128, 8'd127,
                                           1'b1), 1'b0, NO_RESULT});
      directed_rows.push_back('{pixel_item(8'd255, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 1'b1),
                                1'b0, NO_RESULT});
      foreach (directed_rows[i])
         offer(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
      wait_drained();

      // A luma shift of three behaves as two; the dense phase runs against the long hold-off.
      settings.push_back('{1'b1, '0, 2'd3, 1'b0});
      settings.push_back('{1'b0, THRESH_FULL, 2'd0, 1'b0});
      settings.push_back('{1'b1, THRESH_W'($urandom_range(0, 3000)), 2'd1, 1'b1});
      settings.push_back('{1'b0, THRESH_W'($urandom_range(0, 2000)), 2'd2, 1'b0});
      settings.push_back('{1'b1, THRESH_W'($urandom_range(0, 20000)), 2'd0, 1'b0});
      settings.push_back('{1'b0, '0, 2'd1, 1'b0});
      foreach (settings[i]) begin
         write_reg(CSR_SCENE_CHROMA, CSR_DATA_W'(settings[i].uses_chroma));
         write_reg(CSR_THRESHOLD, CSR_DATA_W'(settings[i].threshold));
         write_reg(CSR_LUMA_SHIFT, CSR_DATA_W'(settings[i].luma_shift));
         @(posedge clock);
         if (settings[i].dense)
            hold_off_req = 1'b1;
         stream_random(65, settings[i].dense);
         wait_drained();
      end

      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
